// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define MLB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Same, on the standard clk_i / rst_ni pair.
`define MLB_ASSERT_STD(lbl, prop) `MLB_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/mlb_pkg.sv =====
// Types and constants for the MAC learning bridge.
`default_nettype none

package mlb_pkg;

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned PORT_W = 4;
  localparam int unsigned TIME_W = 32;

  localparam int unsigned SRC_LSB  = 0;
  localparam int unsigned DST_LSB  = SRC_LSB + MAC_W;
  localparam int unsigned PORT_LSB = DST_LSB + MAC_W;
  localparam int unsigned NOW_LSB  = PORT_LSB + PORT_W;
  localparam int unsigned IN_USED_W = NOW_LSB + TIME_W;
  localparam int unsigned IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_USED_W = PORT_W + STATUS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W = OUT_TDATA_W - OUT_USED_W;

  localparam logic [TIME_W-1:0] AGING_RESET = 32'd300;

  typedef enum logic [STATUS_W-1:0] {
    LEARN_REFRESHED = 2'd0,
    LEARN_NEW       = 2'd1,
    LEARN_FULL      = 2'd2
  } learn_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } mlb_state_e;

  typedef struct packed {
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] in_port;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] oldest;
    logic              age_en;
  } mlb_key_t;

  typedef struct packed {
    logic              active;
    logic              src_hit;
    logic              dst_hit;
    logic              free_found;
    logic [PORT_W-1:0] dst_port;
  } mlb_carry_t;

endpackage

`default_nettype wire

// ===== rtl/mlb_cell.sv =====
// One table entry: aging, source/destination match and free-slot claim.
`default_nettype none

module mlb_cell
  import mlb_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire mlb_key_t   key_i,
  input  wire mlb_carry_t carry_i,
  input  wire             alloc_i,
  output mlb_carry_t      carry_o
);

  logic              valid_q;
  logic              cand_q;
  logic              act_q;
  logic [MAC_W-1:0]  mac_q;
  logic [PORT_W-1:0] port_q;
  logic [TIME_W-1:0] stamp_q;

  logic              src_hit_q;
  logic              dst_hit_q;
  logic              free_q;
  logic [PORT_W-1:0] dst_port_q;

  logic aged;
  logic valid_live;
  logic src_m;
  logic dst_m;

  always_comb begin
    aged       = key_i.age_en && (stamp_q < key_i.oldest);
    valid_live = valid_q && !aged;
    src_m      = valid_live && (mac_q == key_i.src_mac);
    dst_m      = valid_live && (mac_q == key_i.dst_mac);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cand_q  <= 1'b0;
      act_q   <= 1'b0;
    end else begin
      act_q <= carry_i.active;
      if (carry_i.active) begin
        valid_q <= valid_live;
        cand_q  <= !valid_live && !carry_i.free_found;
      end else if (alloc_i && cand_q) begin
        valid_q <= 1'b1;
        cand_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (carry_i.active) begin
      src_hit_q  <= carry_i.src_hit || src_m;
      dst_hit_q  <= carry_i.dst_hit || dst_m;
      free_q     <= carry_i.free_found || !valid_live;
      dst_port_q <= carry_i.dst_hit ? carry_i.dst_port : port_q;
      if (src_m) begin
        stamp_q <= key_i.now;
      end
    end else if (alloc_i && cand_q) begin
      mac_q   <= key_i.src_mac;
      port_q  <= key_i.in_port;
      stamp_q <= key_i.now;
    end
  end

  always_comb begin
    carry_o.active     = act_q;
    carry_o.src_hit    = src_hit_q;
    carry_o.dst_hit    = dst_hit_q;
    carry_o.free_found = free_q;
    carry_o.dst_port   = dst_port_q;
  end

endmodule

`default_nettype wire

// ===== rtl/mac_learning_bridge.sv =====
// MAC learning bridge with aging: input header stream in, forwarding result stream out.
//
// Input beat (s_axis): one frame header with source MAC, destination MAC, ingress port
// and current time. Output beat (m_axis): output port and learn status in tdata, flood
// flag in tuser. One output beat per input beat, in order. aging_time is
// written through cfg_wr_en_i / cfg_wr_data_i, by the user only while idle (unchecked).
//
// The table is a row of TABLE_ENTRIES cells. A header is held at the top and
// a carry record walks the row one cell per cycle; each cell ages itself,
// refreshes on a source match, reports a destination match and claims the
// lowest free slot. A new source is written into the claimed cell when its result is
// loaded into the output register.
// A header reaches m_axis_tvalid_o through the start register, the cell row and the
// output register. A new header is accepted only in the idle state, once the last one
// has walked the cell row and its result is loaded; one header is in work at a time.
// Reset empties the table and sets aging_time to 300.
// A stalled receiver holds the result in the output register; the next header
// is still accepted and walks the row, then waits until the register drains.
`default_nettype none

module mac_learning_bridge
  import mlb_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_wr_en_i,
  input  wire  [TIME_W-1:0]      cfg_wr_data_i,
  input  wire                    s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // src_mac[47:0], dst_mac[95:48], in_port[99:96], now[131:100], zero pad
  input  wire  [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  wire                    m_axis_tready_i,
  // out_port[3:0], learn_status[5:4], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // flood[0]
  output logic                   m_axis_tuser_o
);

  mlb_state_e state_q, state_d;

  logic [TIME_W-1:0] aging_q;
  mlb_key_t          key_q;
  logic              same_q;
  logic              start_q;

  logic              out_valid_q;
  logic [PORT_W-1:0] out_port_q;
  logic              flood_q;
  learn_status_e     status_q;

  logic accept_in;
  logic out_free;
  logic load_out;
  logic alloc;
  logic is_new;

  logic [MAC_W-1:0]  in_src;
  logic [MAC_W-1:0]  in_dst;
  logic [TIME_W-1:0] in_now;

  mlb_carry_t carry [TABLE_ENTRIES+1];
  mlb_carry_t carry_end;

  assign in_src = s_axis_tdata_i[SRC_LSB +: MAC_W];
  assign in_dst = s_axis_tdata_i[DST_LSB +: MAC_W];
  assign in_now = s_axis_tdata_i[NOW_LSB +: TIME_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept_in       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign carry_end       = carry[TABLE_ENTRIES];
  assign is_new          = !carry_end.src_hit && carry_end.free_found;

  assign carry[0] = '{
    active:     start_q,
    src_hit:    1'b0,
    dst_hit:    1'b0,
    free_found: 1'b0,
    dst_port:   '0
  };

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    mlb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .carry_i (carry[i]),
      .alloc_i (alloc),
      .carry_o (carry[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (carry_end.active) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    alloc = load_out && is_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aging_q     <= AGING_RESET;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) aging_q <= cfg_wr_data_i;
      start_q <= accept_in;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      key_q.src_mac <= in_src;
      key_q.dst_mac <= in_dst;
      key_q.in_port <= s_axis_tdata_i[PORT_LSB +: PORT_W];
      key_q.now     <= in_now;
      key_q.oldest  <= in_now - aging_q;
      key_q.age_en  <= (in_now >= aging_q);
      same_q        <= (in_src == in_dst);
    end
    if (load_out) begin
      if (carry_end.src_hit) begin
        status_q <= LEARN_REFRESHED;
      end else if (carry_end.free_found) begin
        status_q <= LEARN_NEW;
      end else begin
        status_q <= LEARN_FULL;
      end
      if (carry_end.dst_hit) begin
        out_port_q <= carry_end.dst_port;
        flood_q    <= 1'b0;
      end else if (is_new && same_q) begin
        out_port_q <= key_q.in_port;
        flood_q    <= 1'b0;
      end else begin
        out_port_q <= '0;
        flood_q    <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, status_q, out_port_q};
  assign m_axis_tuser_o  = flood_q;

endmodule

`default_nettype wire

// ===== rtl/mlb_checker.sv =====
// Port-level checker for the MAC learning bridge, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module mlb_checker
  import mlb_pkg::*;
(
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   s_axis_tvalid_i,
  input wire                   s_axis_tready_o,
  input wire                   m_axis_tvalid_o,
  input wire                   m_axis_tready_i,
  input wire [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire                   m_axis_tuser_o
);

  // stalled result beat holds
  `MLB_ASSERT_STD(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  `MLB_ASSERT_STD(a_flood_port, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[PORT_W-1:0] == '0)

  `MLB_ASSERT_STD(a_status_code, m_axis_tvalid_o |-> m_axis_tdata_o[PORT_W +: STATUS_W] != 2'd3 && m_axis_tdata_o[OUT_TDATA_W-1:OUT_USED_W] == '0)

  // one header in work at a time
  `MLB_ASSERT_STD(a_one_in_work, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)

endmodule

bind mac_learning_bridge mlb_checker u_mlb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
